// File: src/rqbi_pkg.sv
// ----------------------------------------------------------------------------
// rqbi_pkg
// Shared types and constants for the ray versus quadratic Bezier intersector.
// ----------------------------------------------------------------------------
package rqbi_pkg;

    localparam int FIELD_W     = 36;
    localparam int A_W         = 38;   // a = y0 - 2*y1 + y2
    localparam int UA_W        = 37;   // |a|
    localparam int B_W         = 38;   // b = 2*(y1 - y0)
    localparam int UB_W        = 37;   // |b|
    localparam int C_W         = 37;   // c = y0 - ray_y
    localparam int UC_W        = 36;   // |c|
    localparam int MB_W        = 38;   // -b with the sign of a folded in
    localparam int HALF_W      = 19;   // split point of the partial products
    localparam int B2_W        = 74;
    localparam int P_W         = 75;
    localparam int D_W         = 76;
    localparam int SQRT_EXTRA  = 16;
    localparam int S_W         = 54;   // floor(sqrt(D * 2^32))
    localparam int REM_W       = 57;
    localparam int T_FRAC      = 24;
    localparam int T_W         = T_FRAC + 1;
    localparam int DEG_EPS_W   = 21;
    localparam int TAN_EPS_W   = 25;
    localparam int CFG_W       = 25;
    localparam int DEN_W       = 54;
    localparam int SPAN_W      = 56;   // m - s and m + s, signed
    localparam int DIV_R_W     = DEN_W + 1;
    localparam int TPROD_W     = 62;
    localparam int TAN_SHIFT   = T_FRAC - SQRT_EXTRA - 1;
    localparam int MID_DEPTH   = 4;
    localparam int OUT_DEPTH   = 2;

    localparam logic [DEG_EPS_W-1:0] DEG_EPS_RESET = DEG_EPS_W'(10);
    localparam logic [TAN_EPS_W-1:0] TAN_EPS_RESET = '0;
    localparam logic [T_W-1:0]       T_ONE         = T_W'(1) << T_FRAC;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_ONE      = 3'd1,
        KIND_TWO      = 3'd2,
        KIND_TANGENT  = 3'd3,
        KIND_PARALLEL = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CLS_FIXED  = 2'd0,
        CLS_LINEAR = 2'd1,
        CLS_QUAD   = 2'd2
    } cls_t;

    typedef enum logic [0:0] {
        REG_DEGENERATE_EPS = 1'b0,
        REG_TANGENT_EPS    = 1'b1
    } reg_index_t;

    // Classified item handed from the front to the back. For the linear case
    // ua holds |b| and mb holds |c|.
    typedef struct packed {
        cls_t                    cls;
        kind_t                   fixed_kind;
        logic [UA_W-1:0]         ua;
        logic [MB_W-1:0]         mb;
        logic [S_W-1:0]          s;
    } front_item_t;

    typedef struct packed {
        kind_t           kind;
        logic [1:0]      count;
        logic [T_W-1:0]  lower_t;
        logic [T_W-1:0]  upper_t;
    } result_t;

endpackage

// File: src/rqbi_fifo.sv
// ----------------------------------------------------------------------------
// rqbi_fifo
// Small flop-based queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module rqbi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rqbi_pkg::MID_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy beyond its depth");

endmodule

// File: src/rqbi_front.sv
// ----------------------------------------------------------------------------
// rqbi_front
// Forms the coefficients, classifies the item and takes the discriminant
// square root in a pipeline of one result bit per stage.
// ----------------------------------------------------------------------------
module rqbi_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [rqbi_pkg::FIELD_W-1:0]          ray_y,
    input  logic [rqbi_pkg::FIELD_W-1:0]          first_ctrl_y,
    input  logic [rqbi_pkg::FIELD_W-1:0]          middle_ctrl_y,
    input  logic [rqbi_pkg::FIELD_W-1:0]          last_ctrl_y,
    input  logic [rqbi_pkg::DEG_EPS_W-1:0]        deg_eps,
    output logic                                  q_push,
    output rqbi_pkg::front_item_t                 q_item,
    input  logic                                  q_full
);

    localparam int A_W    = rqbi_pkg::A_W;
    localparam int B_W    = rqbi_pkg::B_W;
    localparam int C_W    = rqbi_pkg::C_W;
    localparam int UA_W   = rqbi_pkg::UA_W;
    localparam int UB_W   = rqbi_pkg::UB_W;
    localparam int UC_W   = rqbi_pkg::UC_W;
    localparam int MB_W   = rqbi_pkg::MB_W;
    localparam int HW     = rqbi_pkg::HALF_W;
    localparam int B2_W   = rqbi_pkg::B2_W;
    localparam int P_W    = rqbi_pkg::P_W;
    localparam int D_W    = rqbi_pkg::D_W;
    localparam int S_W    = rqbi_pkg::S_W;
    localparam int REM_W  = rqbi_pkg::REM_W;
    localparam int FW     = rqbi_pkg::FIELD_W;
    localparam int EXTRA  = rqbi_pkg::SQRT_EXTRA;

    typedef struct packed {
        rqbi_pkg::cls_t   cls;
        rqbi_pkg::kind_t  kind;
        logic [UA_W-1:0]  ua;
        logic [UB_W-1:0]  ub;
        logic [UC_W-1:0]  uc;
        logic [MB_W-1:0]  mb;
        logic             same;
    } coef_t;

    logic adv;

    // Stage 1: coefficients.
    logic             f1_vld_reg;
    logic [A_W-1:0]   f1_a_reg, f1_a_next;
    logic [B_W-1:0]   f1_b_reg, f1_b_next;
    logic [C_W-1:0]   f1_c_reg, f1_c_next;
    logic [FW:0]      b_half;

    // Stage 2: magnitudes and class.
    logic             f2_vld_reg;
    coef_t            f2_reg, f2_next;
    logic [A_W-1:0]   a_abs;
    logic [B_W-1:0]   b_abs, b_neg;
    logic [C_W-1:0]   c_abs;
    logic             za, zb, zc, lin_ok;

    // Stage 3: partial products.
    logic             f3_vld_reg;
    coef_t            f3_reg;
    logic [35:0]      pb_hh_reg;
    logic [36:0]      pb_hl_reg;
    logic [37:0]      pb_ll_reg;
    logic [34:0]      pp_hh_reg;
    logic [36:0]      pp_hl_reg;
    logic [35:0]      pp_lh_reg;
    logic [37:0]      pp_ll_reg;

    // Stage 4: b^2 and 4|a||c|.
    logic             f4_vld_reg;
    coef_t            f4_reg;
    logic [B2_W-1:0]  b2_reg;
    logic [P_W-1:0]   p_reg;

    // Stage 5 and the square root stages.
    logic                   d_neg;
    logic [D_W-1:0]         d_next;
    rqbi_pkg::front_item_t  item_next;
    logic                   sq_vld_reg  [0:S_W];
    rqbi_pkg::front_item_t  sq_item_reg [0:S_W];
    logic [S_W-1:0]         sq_root_reg [0:S_W];
    logic [REM_W-1:0]       sq_rem_reg  [0:S_W-1];
    logic [D_W-1:0]         sq_d_reg    [0:S_W-1];

    assign adv    = !sq_vld_reg[S_W] || !q_full;
    assign full   = !adv;
    assign q_push = sq_vld_reg[S_W] && !q_full;

    always_comb
    begin
        q_item   = sq_item_reg[S_W];
        q_item.s = sq_root_reg[S_W];
    end

    // Coefficients, exact in coordinate LSBs.
    assign f1_a_next = {{2{first_ctrl_y[FW-1]}}, first_ctrl_y}
                     - {middle_ctrl_y[FW-1], middle_ctrl_y, 1'b0}
                     + {{2{last_ctrl_y[FW-1]}}, last_ctrl_y};
    assign b_half    = {middle_ctrl_y[FW-1], middle_ctrl_y}
                     - {first_ctrl_y[FW-1], first_ctrl_y};
    assign f1_b_next = {b_half, 1'b0};
    assign f1_c_next = {first_ctrl_y[FW-1], first_ctrl_y} - {ray_y[FW-1], ray_y};

    always_comb
    begin
        a_abs  = f1_a_reg[A_W-1] ? (~f1_a_reg + 1'b1) : f1_a_reg;
        b_neg  = ~f1_b_reg + 1'b1;
        b_abs  = f1_b_reg[B_W-1] ? b_neg : f1_b_reg;
        c_abs  = f1_c_reg[C_W-1] ? (~f1_c_reg + 1'b1) : f1_c_reg;

        f2_next.ua = a_abs[UA_W-1:0];
        f2_next.ub = b_abs[UB_W-1:0];
        f2_next.uc = c_abs[UC_W-1:0];
        // Folded -b: negated when a is positive.
        f2_next.mb   = f1_a_reg[A_W-1] ? f1_b_reg : b_neg;
        f2_next.same = (f1_c_reg != '0) && (f1_a_reg[A_W-1] == f1_c_reg[C_W-1]);

        za = (f2_next.ua == '0) || (f2_next.ua < UA_W'(deg_eps));
        zb = (f2_next.ub == '0) || (f2_next.ub < UB_W'(deg_eps));
        zc = (f2_next.uc == '0) || (f2_next.uc < UC_W'(deg_eps));
        // Linear root -c/b lies in [0,1].
        lin_ok = ((f1_c_reg == '0) || (f1_c_reg[C_W-1] != f1_b_reg[B_W-1]))
               && (UB_W'(f2_next.uc) <= f2_next.ub);

        f2_next.cls  = rqbi_pkg::CLS_QUAD;
        f2_next.kind = rqbi_pkg::KIND_NONE;
        if (za)
        begin
            if (zb)
            begin
                f2_next.cls  = rqbi_pkg::CLS_FIXED;
                f2_next.kind = zc ? rqbi_pkg::KIND_PARALLEL : rqbi_pkg::KIND_NONE;
            end
            else if (lin_ok)
            begin
                f2_next.cls = rqbi_pkg::CLS_LINEAR;
            end
            else
            begin
                f2_next.cls = rqbi_pkg::CLS_FIXED;
            end
        end
    end

    // Discriminant and final class.
    always_comb
    begin
        d_neg  = 1'b0;
        d_next = D_W'(b2_reg) + D_W'(p_reg);
        if (f4_reg.same)
        begin
            if (P_W'(b2_reg) >= p_reg)
            begin
                d_next = D_W'(b2_reg) - D_W'(p_reg);
            end
            else
            begin
                d_neg = 1'b1;
            end
        end

        item_next.cls        = f4_reg.cls;
        item_next.fixed_kind = f4_reg.kind;
        item_next.ua         = f4_reg.ua;
        item_next.mb         = f4_reg.mb;
        item_next.s          = '0;
        if (f4_reg.cls == rqbi_pkg::CLS_LINEAR)
        begin
            item_next.ua = UA_W'(f4_reg.ub);
            item_next.mb = MB_W'(f4_reg.uc);
        end
        else if (f4_reg.cls == rqbi_pkg::CLS_QUAD && d_neg)
        begin
            item_next.cls        = rqbi_pkg::CLS_FIXED;
            item_next.fixed_kind = rqbi_pkg::KIND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg    <= 1'b0;
            f2_vld_reg    <= 1'b0;
            f3_vld_reg    <= 1'b0;
            f4_vld_reg    <= 1'b0;
            sq_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            f1_vld_reg    <= push;
            f2_vld_reg    <= f1_vld_reg;
            f3_vld_reg    <= f2_vld_reg;
            f4_vld_reg    <= f3_vld_reg;
            sq_vld_reg[0] <= f4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_a_reg  <= f1_a_next;
            f1_b_reg  <= f1_b_next;
            f1_c_reg  <= f1_c_next;
            f2_reg    <= f2_next;
            f3_reg    <= f2_reg;
            pb_hh_reg <= f2_reg.ub[UB_W-1:HW] * f2_reg.ub[UB_W-1:HW];
            pb_hl_reg <= f2_reg.ub[UB_W-1:HW] * f2_reg.ub[HW-1:0];
            pb_ll_reg <= f2_reg.ub[HW-1:0] * f2_reg.ub[HW-1:0];
            pp_hh_reg <= f2_reg.ua[UA_W-1:HW] * f2_reg.uc[UC_W-1:HW];
            pp_hl_reg <= f2_reg.ua[UA_W-1:HW] * f2_reg.uc[HW-1:0];
            pp_lh_reg <= f2_reg.ua[HW-1:0] * f2_reg.uc[UC_W-1:HW];
            pp_ll_reg <= f2_reg.ua[HW-1:0] * f2_reg.uc[HW-1:0];
            f4_reg    <= f3_reg;
            b2_reg    <= B2_W'({pb_hh_reg, 38'b0}) + B2_W'({pb_hl_reg, 20'b0})
                       + B2_W'(pb_ll_reg);
            p_reg     <= P_W'({pp_hh_reg, 40'b0}) + P_W'({pp_hl_reg, 21'b0})
                       + P_W'({pp_lh_reg, 21'b0}) + P_W'({pp_ll_reg, 2'b0});
            sq_item_reg[0] <= item_next;
            sq_d_reg[0]    <= d_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // Restoring square root over the radicand D * 2^32, two radicand bits and
    // one root bit per stage.
    for (genvar k = 0; k < S_W; k++)
    begin : g_sqrt
        localparam int P = S_W - 1 - k;
        logic [1:0]       digits;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             ge;

        if (P >= EXTRA)
        begin : g_data
            assign digits = sq_d_reg[k][2*P-2*EXTRA+1:2*P-2*EXTRA];
        end
        else
        begin : g_zero
            assign digits = 2'b00;
        end

        assign rem_sh = {sq_rem_reg[k][REM_W-3:0], digits};
        assign trial  = REM_W'({sq_root_reg[k], 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_item_reg[k+1] <= sq_item_reg[k];
                sq_root_reg[k+1] <= {sq_root_reg[k][S_W-2:0], ge};
            end
        end

        if (k + 1 < S_W)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_rem_reg[k+1] <= ge ? (rem_sh - trial) : rem_sh;
                    sq_d_reg[k+1]   <= sq_d_reg[k];
                end
            end
        end
    end

    a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_vld_reg[S_W] && q_full) |=> (sq_vld_reg[S_W] && $stable(q_item)))
        else $error("front output item lost while the queue was full");

endmodule

// File: src/rqbi_back.sv
// ----------------------------------------------------------------------------
// rqbi_back
// Tangent test, root range checks and a bit-per-stage divider pipeline that
// turns the surviving roots into t values.
// ----------------------------------------------------------------------------
module rqbi_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [rqbi_pkg::TAN_EPS_W-1:0]       tan_eps,
    input  logic                                 q_empty,
    input  rqbi_pkg::front_item_t                q_item,
    output logic                                 q_pop,
    output logic                                 out_push,
    output rqbi_pkg::result_t                    out_item,
    input  logic                                 out_full
);

    localparam int UA_W    = rqbi_pkg::UA_W;
    localparam int MB_W    = rqbi_pkg::MB_W;
    localparam int HW      = rqbi_pkg::HALF_W;
    localparam int S_W     = rqbi_pkg::S_W;
    localparam int SPAN_W  = rqbi_pkg::SPAN_W;
    localparam int DEN_W   = rqbi_pkg::DEN_W;
    localparam int R_W     = rqbi_pkg::DIV_R_W;
    localparam int TP_W    = rqbi_pkg::TPROD_W;
    localparam int T_FRAC  = rqbi_pkg::T_FRAC;
    localparam int T_W     = rqbi_pkg::T_W;
    localparam int EXTRA   = rqbi_pkg::SQRT_EXTRA;
    localparam int DV_N    = T_FRAC + 2;

    typedef struct packed {
        rqbi_pkg::kind_t          kind;
        logic [1:0]               count;
        logic [DEN_W-1:0]         den;
        logic [1:0]               sat;
        logic [1:0]               rnd;
        logic [1:0][R_W-1:0]      r;
        logic [1:0][T_FRAC-1:0]   q;
    } div_stage_t;

    logic adv;

    // Stage b1.
    logic                   b1_vld_reg;
    rqbi_pkg::front_item_t  b1_item_reg;
    logic [42:0]            tp_h_reg;
    logic [43:0]            tp_l_reg;
    logic [SPAN_W-1:0]      lo_reg, hi_reg;
    logic [SPAN_W-1:0]      m_val;

    // Stage b2.
    logic                   b2_vld_reg;
    rqbi_pkg::front_item_t  b2_item_reg;
    logic [TP_W-1:0]        tprod_reg;
    logic                   lo_ok_reg, hi_ok_reg, tan_ok_reg;
    logic [DEN_W-1:0]       lo_num_reg, hi_num_reg;
    logic [DEN_W-1:0]       den_b1;

    // Divider pipeline; entry 0 is loaded by stage b3.
    logic                   dv_vld_reg [0:DV_N-1];
    div_stage_t             dv_reg     [0:DV_N-1];
    div_stage_t             dv0_next;
    logic                   tangent;
    logic [1:0]             quad_count;
    logic [1:0][T_W-1:0]    lane_t;

    assign adv      = !dv_vld_reg[DV_N-1] || !out_full;
    assign q_pop    = adv && !q_empty;
    assign out_push = dv_vld_reg[DV_N-1] && !out_full;

    assign m_val  = {{2{q_item.mb[MB_W-1]}}, q_item.mb, {EXTRA{1'b0}}};
    assign den_b1 = {b1_item_reg.ua, {(EXTRA + 1){1'b0}}};

    // Selection of the divisions that stage b3 starts.
    always_comb
    begin
        tangent    = (TP_W'({b2_item_reg.s, {rqbi_pkg::TAN_SHIFT{1'b0}}}) <= tprod_reg);
        quad_count = {1'b0, lo_ok_reg} + {1'b0, hi_ok_reg};

        dv0_next.kind  = b2_item_reg.fixed_kind;
        dv0_next.count = 2'd0;
        dv0_next.den   = {b2_item_reg.ua, {(EXTRA + 1){1'b0}}};
        dv0_next.sat   = 2'b00;
        dv0_next.rnd   = 2'b00;
        dv0_next.r[0]  = R_W'(lo_ok_reg ? lo_num_reg : hi_num_reg);
        dv0_next.r[1]  = R_W'(hi_num_reg);
        dv0_next.q     = '0;

        unique case (b2_item_reg.cls)
            rqbi_pkg::CLS_LINEAR:
            begin
                dv0_next.kind  = rqbi_pkg::KIND_ONE;
                dv0_next.count = 2'd1;
                dv0_next.den   = DEN_W'(b2_item_reg.ua);
                dv0_next.r[0]  = R_W'(b2_item_reg.mb);
            end
            rqbi_pkg::CLS_QUAD:
            begin
                if (tangent)
                begin
                    dv0_next.den  = DEN_W'({b2_item_reg.ua, 1'b0});
                    dv0_next.r[0] = R_W'(b2_item_reg.mb);
                    if (tan_ok_reg)
                    begin
                        dv0_next.kind  = rqbi_pkg::KIND_TANGENT;
                        dv0_next.count = 2'd1;
                    end
                    else
                    begin
                        dv0_next.kind = rqbi_pkg::KIND_NONE;
                    end
                end
                else
                begin
                    dv0_next.count = quad_count;
                    unique case (quad_count)
                        2'd1:    dv0_next.kind = rqbi_pkg::KIND_ONE;
                        2'd2:    dv0_next.kind = rqbi_pkg::KIND_TWO;
                        default: dv0_next.kind = rqbi_pkg::KIND_NONE;
                    endcase
                end
            end
            default:
            begin
                dv0_next.count = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg    <= 1'b0;
            b2_vld_reg    <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            b1_vld_reg    <= !q_empty;
            b2_vld_reg    <= b1_vld_reg;
            dv_vld_reg[0] <= b2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_item_reg <= q_item;
            tp_h_reg    <= tan_eps * q_item.ua[UA_W-1:HW];
            tp_l_reg    <= tan_eps * q_item.ua[HW-1:0];
            lo_reg      <= m_val - SPAN_W'(q_item.s);
            hi_reg      <= m_val + SPAN_W'(q_item.s);

            b2_item_reg <= b1_item_reg;
            tprod_reg   <= TP_W'({tp_h_reg, {HW{1'b0}}}) + TP_W'(tp_l_reg);
            lo_ok_reg   <= !lo_reg[SPAN_W-1] && (lo_reg[SPAN_W-2:0] <= R_W'(den_b1));
            hi_ok_reg   <= !hi_reg[SPAN_W-1] && (hi_reg[SPAN_W-2:0] <= R_W'(den_b1));
            tan_ok_reg  <= !b1_item_reg.mb[MB_W-1]
                        && (b1_item_reg.mb <= MB_W'({b1_item_reg.ua, 1'b0}));
            lo_num_reg  <= lo_reg[DEN_W-1:0];
            hi_num_reg  <= hi_reg[DEN_W-1:0];

            dv_reg[0]   <= dv0_next;
        end
    end

    // One quotient bit per stage, then a stage for the rounding bit.
    for (genvar j = 1; j < DV_N; j++)
    begin : g_div
        div_stage_t st_next;

        always_comb
        begin
            logic [R_W-1:0] sh;
            logic           ge;
            st_next = dv_reg[j-1];
            for (int ln = 0; ln < 2; ln++)
            begin
                sh = {dv_reg[j-1].r[ln][R_W-2:0], 1'b0};
                ge = (sh >= R_W'(dv_reg[j-1].den));
                if (j == 1)
                begin
                    st_next.sat[ln] = (dv_reg[j-1].r[ln] >= R_W'(dv_reg[j-1].den));
                end
                if (j <= T_FRAC)
                begin
                    st_next.r[ln] = ge ? (sh - R_W'(dv_reg[j-1].den)) : sh;
                    st_next.q[ln] = {dv_reg[j-1].q[ln][T_FRAC-2:0], ge};
                end
                else
                begin
                    st_next.rnd[ln] = ge;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_vld_reg[j] <= dv_vld_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[j] <= st_next;
            end
        end
    end

    always_comb
    begin
        for (int ln = 0; ln < 2; ln++)
        begin
            lane_t[ln] = dv_reg[DV_N-1].sat[ln] ? rqbi_pkg::T_ONE
                       : (T_W'(dv_reg[DV_N-1].q[ln]) + T_W'(dv_reg[DV_N-1].rnd[ln]));
        end
        out_item.kind    = dv_reg[DV_N-1].kind;
        out_item.count   = dv_reg[DV_N-1].count;
        out_item.lower_t = (dv_reg[DV_N-1].count != 2'd0) ? lane_t[0] : '0;
        out_item.upper_t = (dv_reg[DV_N-1].count == 2'd2) ? lane_t[1] : '0;
    end

    a_upper_only_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_item.upper_t == '0 || out_item.count == 2'd2))
        else $error("upper_t set without two roots");

    a_tangent_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && out_item.kind == rqbi_pkg::KIND_TANGENT) |-> out_item.count == 2'd1)
        else $error("tangent result without exactly one root");

endmodule

// File: src/ray_quadratic_bezier_intersect.sv
// ----------------------------------------------------------------------------
// ray_quadratic_bezier_intersect
// Horizontal ray against a quadratic Bezier curve in y: classifies the
// quadratic, takes the discriminant root and returns the in-range t values.
// ----------------------------------------------------------------------------
// An item passes through 59 front stages, one middle queue entry, 28 back stages
// (b1, b2, stage b3, then one quotient bit per stage and a rounding stage)
// and one result queue entry before it reaches the result ports.
// Throughput: one item per cycle when nothing stalls.
// Reset clears all valid flags and both queues and loads degenerate_epsilon
// with 10 and tangent_epsilon with 0; there is no clearing pass.
module ray_quadratic_bezier_intersect #(
    parameter int MID_QUEUE_DEPTH = rqbi_pkg::MID_DEPTH,
    parameter int OUT_QUEUE_DEPTH = rqbi_pkg::OUT_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [rqbi_pkg::FIELD_W-1:0]      ray_y,
    input  logic [rqbi_pkg::FIELD_W-1:0]      first_ctrl_y,
    input  logic [rqbi_pkg::FIELD_W-1:0]      middle_ctrl_y,
    input  logic [rqbi_pkg::FIELD_W-1:0]      last_ctrl_y,
    output logic                              empty,
    input  logic                              pop,
    output logic [2:0]                        hit_kind,
    output logic [1:0]                        root_count,
    output logic [rqbi_pkg::T_W-1:0]          lower_t,
    output logic [rqbi_pkg::T_W-1:0]          upper_t,
    input  logic                              cfg_en,
    input  logic [0:0]                        cfg_addr,
    input  logic [rqbi_pkg::CFG_W-1:0]        cfg_data
);

    localparam int ITEM_W   = $bits(rqbi_pkg::front_item_t);
    localparam int RESULT_W = $bits(rqbi_pkg::result_t);

    logic [rqbi_pkg::DEG_EPS_W-1:0] deg_eps_reg;
    logic [rqbi_pkg::TAN_EPS_W-1:0] tan_eps_reg;

    logic                   mid_push, mid_full, mid_pop, mid_empty;
    rqbi_pkg::front_item_t  mid_wr_item, mid_rd_item;
    logic [ITEM_W-1:0]      mid_rd_bits;
    logic                   res_push, res_full;
    rqbi_pkg::result_t      res_wr_item, res_rd_item;
    logic [RESULT_W-1:0]    res_rd_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_eps_reg <= rqbi_pkg::DEG_EPS_RESET;
            tan_eps_reg <= rqbi_pkg::TAN_EPS_RESET;
        end
        else if (cfg_en)
        begin
            unique case (rqbi_pkg::reg_index_t'(cfg_addr))
                rqbi_pkg::REG_DEGENERATE_EPS:
                    deg_eps_reg <= cfg_data[rqbi_pkg::DEG_EPS_W-1:0];
                rqbi_pkg::REG_TANGENT_EPS:
                    tan_eps_reg <= cfg_data[rqbi_pkg::TAN_EPS_W-1:0];
                default:
                    deg_eps_reg <= deg_eps_reg;
            endcase
        end
    end

    rqbi_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .ray_y         (ray_y),
        .first_ctrl_y  (first_ctrl_y),
        .middle_ctrl_y (middle_ctrl_y),
        .last_ctrl_y   (last_ctrl_y),
        .deg_eps       (deg_eps_reg),
        .q_push        (mid_push),
        .q_item        (mid_wr_item),
        .q_full        (mid_full)
    );

    rqbi_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_QUEUE_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_push),
        .wr_data (mid_wr_item),
        .full    (mid_full),
        .pop     (mid_pop),
        .rd_data (mid_rd_bits),
        .empty   (mid_empty)
    );

    assign mid_rd_item = rqbi_pkg::front_item_t'(mid_rd_bits);

    rqbi_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .tan_eps  (tan_eps_reg),
        .q_empty  (mid_empty),
        .q_item   (mid_rd_item),
        .q_pop    (mid_pop),
        .out_push (res_push),
        .out_item (res_wr_item),
        .out_full (res_full)
    );

    rqbi_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_wr_item),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd_bits),
        .empty   (empty)
    );

    assign res_rd_item = rqbi_pkg::result_t'(res_rd_bits);
    assign hit_kind    = res_rd_item.kind;
    assign root_count  = res_rd_item.count;
    assign lower_t     = res_rd_item.lower_t;
    assign upper_t     = res_rd_item.upper_t;

endmodule
